>>> rtl/core/bra_pkg.sv
// Shared types, widths and constants of the bounded rational approximation block.
// No dependencies; every other file of the block imports this package.
package bra_pkg;

   localparam int VALUE_WIDTH = 64;   // bits of the input fraction that are used
   localparam int MAX_TERMS   = 96;   // continued-fraction terms before the expansion stops
   localparam int FIELD_W     = 64;   // width of the request fields
   localparam int LIMIT_W     = 32;   // width of the limit registers and of the result
   localparam int ACC_W       = LIMIT_W + 1;  // convergent terms, saturated one above any limit
   localparam int TERM_W      = $clog2(MAX_TERMS + 1);
   localparam int CNT_W       = $clog2(VALUE_WIDTH);
   localparam int CSR_INDEX_W = 1;

   localparam logic [ACC_W-1:0]  SAT_VALUE    = {1'b1, {LIMIT_W{1'b0}}};
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(1048575);

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_NUMERATOR_LIMIT   = 1'b0,
      CSR_DENOMINATOR_LIMIT = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_DIVIDE,
      ST_UPDATE,
      ST_DONE
   } eng_state_type;

   typedef struct packed {
      logic start;   // a request is accepted this cycle
      logic take;    // the output register can take the result
   } eng_ctrl_type;

   typedef struct packed {
      logic idle;    // engine can accept a request
      logic done;    // result is held and waiting to be taken
   } eng_status_type;

   // Clamp a grown convergent value: anything at or above 2^LIMIT_W exceeds every limit.
   function automatic logic [ACC_W-1:0] sat_acc(input logic [ACC_W+1:0] x);
      logic [ACC_W-1:0] y;
      if (x[ACC_W+1:LIMIT_W] != '0) begin
         y = SAT_VALUE;
      end else begin
         y = {1'b0, x[LIMIT_W-1:0]};
      end
      return y;
   endfunction

endpackage

>>> rtl/core/bra_req_if.sv
// Request channel of the bounded rational approximation block: valid/ready plus fraction.
// Depends on bra_pkg for the field width.
interface bra_req_if import bra_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [FIELD_W-1:0] value_numerator;
   logic [FIELD_W-1:0] value_denominator;

   modport source (output valid, output value_numerator, output value_denominator,
                   input ready);
   modport sink   (input valid, input value_numerator, input value_denominator,
                   output ready);
endinterface

>>> rtl/core/bra_rsp_if.sv
// Result channel of the bounded rational approximation block: valid/ready plus convergent.
// Depends on bra_pkg for the result width.
interface bra_rsp_if import bra_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [LIMIT_W-1:0] approx_numerator;
   logic [LIMIT_W-1:0] approx_denominator;

   modport source (output valid, output approx_numerator, output approx_denominator,
                   input ready);
   modport sink   (input valid, input approx_numerator, input approx_denominator,
                   output ready);
endinterface

>>> rtl/core/bra_cf_engine.sv
// Continued-fraction engine: sequencer plus one shift-subtract divider step unit.
// Depends on bra_pkg for widths, state and control types and the saturating helper.
module bra_cf_engine import bra_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  eng_ctrl_type       ctrl,
   input  logic [FIELD_W-1:0] value_numerator,
   input  logic [FIELD_W-1:0] value_denominator,
   input  logic [LIMIT_W-1:0] numerator_limit,
   input  logic [LIMIT_W-1:0] denominator_limit,
   output eng_status_type     status,
   output logic [LIMIT_W-1:0] result_numerator,
   output logic [LIMIT_W-1:0] result_denominator
);

   eng_state_type state_ff, state_in;

   logic [VALUE_WIDTH-1:0] num_ff, num_in;
   logic [VALUE_WIDTH-1:0] den_ff, den_in;
   logic [VALUE_WIDTH-1:0] rem_ff, rem_in;
   logic [VALUE_WIDTH-1:0] dvd_ff, dvd_in;
   logic [CNT_W-1:0]       bit_cnt_ff, bit_cnt_in;
   logic [TERM_W-1:0]      terms_ff, terms_in;
   logic [ACC_W-1:0]       h0_ff, h0_in, h1_ff, h1_in;
   logic [ACC_W-1:0]       k0_ff, k0_in, k1_ff, k1_in;
   logic [ACC_W-1:0]       acc_h_ff, acc_h_in, acc_k_ff, acc_k_in;
   logic [LIMIT_W-1:0]     res_num_ff, res_num_in, res_den_ff, res_den_in;

   logic [VALUE_WIDTH:0]   rem_shift;
   logic [VALUE_WIDTH-1:0] rem_diff;
   logic                   quot_bit;

   localparam logic [CNT_W-1:0]  CNT_LAST  = CNT_W'(VALUE_WIDTH - 1);
   localparam logic [TERM_W-1:0] TERM_LAST = TERM_W'(MAX_TERMS);

   // Restoring divider step: one quotient bit per cycle, MSB first.
   assign rem_shift = {rem_ff, dvd_ff[VALUE_WIDTH-1]};
   assign rem_diff  = rem_shift[VALUE_WIDTH-1:0] - den_ff;
   assign quot_bit  = (rem_shift >= {1'b0, den_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      num_ff     <= num_in;
      den_ff     <= den_in;
      rem_ff     <= rem_in;
      dvd_ff     <= dvd_in;
      bit_cnt_ff <= bit_cnt_in;
      terms_ff   <= terms_in;
      h0_ff      <= h0_in;
      h1_ff      <= h1_in;
      k0_ff      <= k0_in;
      k1_ff      <= k1_in;
      acc_h_ff   <= acc_h_in;
      acc_k_ff   <= acc_k_in;
      res_num_ff <= res_num_in;
      res_den_ff <= res_den_in;
   end

   always_comb begin
      state_in    = state_ff;
      num_in      = num_ff;
      den_in      = den_ff;
      rem_in      = rem_ff;
      dvd_in      = dvd_ff;
      bit_cnt_in  = bit_cnt_ff;
      terms_in    = terms_ff;
      h0_in       = h0_ff;
      h1_in       = h1_ff;
      k0_in       = k0_ff;
      k1_in       = k1_ff;
      acc_h_in    = acc_h_ff;
      acc_k_in    = acc_k_ff;
      res_num_in  = res_num_ff;
      res_den_in  = res_den_ff;
      status.idle = 1'b0;
      status.done = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            status.idle = 1'b1;
            if (ctrl.start) begin
               num_in   = value_numerator[VALUE_WIDTH-1:0];
               den_in   = value_denominator[VALUE_WIDTH-1:0];
               h0_in    = '0;
               h1_in    = ACC_W'(1);
               k0_in    = ACC_W'(1);
               k1_in    = '0;
               terms_in = '0;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (h1_ff > {1'b0, numerator_limit} || k1_ff > {1'b0, denominator_limit}) begin
               // newest convergent is over a limit: fall back to the previous one
               res_num_in = h0_ff[LIMIT_W-1:0];
               res_den_in = k0_ff[LIMIT_W-1:0];
               state_in   = ST_DONE;
            end else if (den_ff == '0 || terms_ff == TERM_LAST) begin
               res_num_in = h1_ff[LIMIT_W-1:0];
               res_den_in = k1_ff[LIMIT_W-1:0];
               state_in   = ST_DONE;
            end else begin
               rem_in     = '0;
               dvd_in     = num_ff;
               bit_cnt_in = '0;
               acc_h_in   = '0;
               acc_k_in   = '0;
               state_in   = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            // fold each quotient bit straight into q*h1 and q*k1
            rem_in   = quot_bit ? rem_diff : rem_shift[VALUE_WIDTH-1:0];
            dvd_in   = {dvd_ff[VALUE_WIDTH-2:0], 1'b0};
            acc_h_in = sat_acc({1'b0, acc_h_ff, 1'b0} + {2'b00, (quot_bit ? h1_ff : '0)});
            acc_k_in = sat_acc({1'b0, acc_k_ff, 1'b0} + {2'b00, (quot_bit ? k1_ff : '0)});
            if (bit_cnt_ff == CNT_LAST) begin
               state_in = ST_UPDATE;
            end else begin
               bit_cnt_in = bit_cnt_ff + CNT_W'(1);
            end
         end
         ST_UPDATE: begin
            num_in   = den_ff;
            den_in   = rem_ff;
            h1_in    = sat_acc({2'b00, acc_h_ff} + {2'b00, h0_ff});
            k1_in    = sat_acc({2'b00, acc_k_ff} + {2'b00, k0_ff});
            h0_in    = h1_ff;
            k0_in    = k1_ff;
            terms_in = terms_ff + TERM_W'(1);
            state_in = ST_CHECK;
         end
         ST_DONE: begin
            status.done = 1'b1;
            if (ctrl.take) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign result_numerator   = res_num_ff;
   assign result_denominator = res_den_ff;

endmodule

>>> rtl/core/bounded_rational_approximation.sv
// Top level of the bounded rational approximation block: limit registers, engine, result register.
// Depends on bra_pkg, bra_req_if, bra_rsp_if and bra_cf_engine.
//
// Takes one request (a VALUE_WIDTH-bit fraction) at a time and returns the last
// continued-fraction convergent whose numerator and denominator stay within the
// numerator_limit and denominator_limit registers (both reset to 1048575). If the
// newest convergent passes a limit, the one before it is returned; a zero
// denominator gives 1/0 and a zero numerator limit gives 0/1. Semiconvergents
// are not tried, and the expansion stops after MAX_TERMS terms. Each term runs
// through one limit check, VALUE_WIDTH shift-subtract steps of the divider and
// one recurrence update. The single divider step unit retires one quotient bit
// per cycle and builds q*h and q*k on the fly with saturating shift-adds.
// req_chan.ready is high only while the engine is idle; a finished result sits
// in the output register, so the next request can be accepted while the
// previous result is still waiting. Write the limit registers only while no
// request is in flight.
module bounded_rational_approximation import bra_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   bra_req_if.sink                req_chan,
   bra_rsp_if.source              rsp_chan,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [LIMIT_W-1:0]     csr_write_data
);

   logic [LIMIT_W-1:0] num_limit_ff, num_limit_in;
   logic [LIMIT_W-1:0] den_limit_ff, den_limit_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [LIMIT_W-1:0] rsp_num_ff, rsp_num_in;
   logic [LIMIT_W-1:0] rsp_den_ff, rsp_den_in;

   eng_ctrl_type       eng_ctrl;
   eng_status_type     eng_status;
   logic [LIMIT_W-1:0] eng_num;
   logic [LIMIT_W-1:0] eng_den;

   // Limit registers: decode the index, drop writes to nothing.
   always_comb begin
      num_limit_in = num_limit_ff;
      den_limit_in = den_limit_ff;
      if (csr_write_enable) begin
         case (csr_index_type'(csr_index))
            CSR_NUMERATOR_LIMIT:   num_limit_in = csr_write_data;
            CSR_DENOMINATOR_LIMIT: den_limit_in = csr_write_data;
            default: begin
               num_limit_in = num_limit_ff;
            end
         endcase
      end
   end

   // Accept a request only while the engine is idle.
   assign req_chan.ready = eng_status.idle;
   assign eng_ctrl.start = req_chan.valid & eng_status.idle;
   // Hand the result over when the output register is empty or being drained.
   assign eng_ctrl.take  = ~rsp_valid_ff | rsp_chan.ready;

   bra_cf_engine u_engine (
      .clock              (clock),
      .reset              (reset),
      .ctrl               (eng_ctrl),
      .value_numerator    (req_chan.value_numerator),
      .value_denominator  (req_chan.value_denominator),
      .numerator_limit    (num_limit_ff),
      .denominator_limit  (den_limit_ff),
      .status             (eng_status),
      .result_numerator   (eng_num),
      .result_denominator (eng_den)
   );

   // Output register: load on handover, drop valid when taken with nothing new.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_num_in   = rsp_num_ff;
      rsp_den_in   = rsp_den_ff;
      if (eng_status.done && eng_ctrl.take) begin
         rsp_valid_in = 1'b1;
         rsp_num_in   = eng_num;
         rsp_den_in   = eng_den;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_limit_ff <= LIMIT_RESET;
         den_limit_ff <= LIMIT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         num_limit_ff <= num_limit_in;
         den_limit_ff <= den_limit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_num_ff <= rsp_num_in;
      rsp_den_ff <= rsp_den_in;
   end

   assign rsp_chan.valid              = rsp_valid_ff;
   assign rsp_chan.approx_numerator   = rsp_num_ff;
   assign rsp_chan.approx_denominator = rsp_den_ff;

endmodule

>>> rtl/core/bra_checker.sv
// Port-level checks of the bounded rational approximation block, bound to its top level.
// Depends on bra_pkg for the result width.
module bra_checker import bra_pkg::*; (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [LIMIT_W-1:0] approx_numerator,
   input logic [LIMIT_W-1:0] approx_denominator
);

   // Hold a stalled result and its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(approx_numerator)
                                  && $stable(approx_denominator))
      else $error("stalled result dropped or changed");

   // A request keeps the engine busy for at least the next cycle.
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("ready again right after a request");

   // The only zero denominator is 1/0.
   a_zero_den: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && approx_denominator == '0 |-> approx_numerator == LIMIT_W'(1))
      else $error("zero denominator without numerator one");

   // The only zero numerator is 0/1.
   a_zero_num: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && approx_numerator == '0 |-> approx_denominator == LIMIT_W'(1))
      else $error("zero numerator without denominator one");

endmodule

bind bounded_rational_approximation bra_checker u_bra_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_chan.valid),
   .req_ready          (req_chan.ready),
   .rsp_valid          (rsp_chan.valid),
   .rsp_ready          (rsp_chan.ready),
   .approx_numerator   (rsp_chan.approx_numerator),
   .approx_denominator (rsp_chan.approx_denominator)
);

>>> tb/sv/tb_bounded_rational_approximation.sv
// Self-checking testbench of bounded_rational_approximation: the limit registers under
// directed and random fractions. Depends on bra_pkg, bra_req_if, bra_rsp_if and the block.
module tb_bounded_rational_approximation import bra_pkg::*; ();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CLOCK_PERIOD  = 4;
   localparam int RESET_CYCLES  = 4;
   localparam int SETTLE_CYCLES = 8;     // quiet cycles before touching the limit registers
   localparam int DRAIN_CYCLES  = 7000;  // above the longest expansion
   localparam int RANDOM_PER_PHASE = 25;
   localparam logic [FIELD_W-1:0] VALUE_MASK = {FIELD_W{1'b1}} >> (FIELD_W - VALUE_WIDTH);

   typedef struct packed {
      logic [FIELD_W-1:0] numer;
      logic [FIELD_W-1:0] denom;
   } fraction_type;

   typedef struct packed {
      logic [LIMIT_W-1:0] numer;
      logic [LIMIT_W-1:0] denom;
   } convergent_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                   csr_write_enable;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [LIMIT_W-1:0]     csr_write_data;

   bra_req_if req_chan ();
   bra_rsp_if rsp_chan ();

   bounded_rational_approximation u_top (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_chan),
      .rsp_chan         (rsp_chan),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // Local copy of the limit registers, kept in step with every write.
   logic [LIMIT_W-1:0] numerator_limit   = LIMIT_RESET;
   logic [LIMIT_W-1:0] denominator_limit = LIMIT_RESET;

   fraction_type   pending_fractions[$];     // requests waiting to be driven
   convergent_type expected_convergents[$];  // predictions of accepted requests
   int requests_queued = 0;
   int results_seen    = 0;
   int error_count     = 0;
   int sender_idle_pct   = 0;
   int receiver_stall_pct = 0;

   // base + mul * fac, clamped at all ones instead of wrapping.
   function automatic logic [63:0] mul_add_saturated(input logic [63:0] base,
                                                     input logic [63:0] mul,
                                                     input logic [63:0] fac);
      logic [127:0] full;
      full = 128'(mul) * 128'(fac) + 128'(base);
      return (full[127:64] != '0) ? '1 : full[63:0];
   endfunction

   // Expand the fraction as a continued fraction and keep the last convergent that
   // fits both limits; fall back one convergent as soon as a limit is passed.
   function automatic convergent_type best_convergent(input fraction_type value,
                                                      input logic [LIMIT_W-1:0] numer_lim,
                                                      input logic [LIMIT_W-1:0] denom_lim);
      logic [63:0] numer, denom, quot, rem, grown;
      logic [63:0] h_prev, h_cur, k_prev, k_cur;
      int unsigned terms;
      convergent_type result;
      numer  = value.numer & VALUE_MASK;
      denom  = value.denom & VALUE_MASK;
      h_prev = 64'd0;
      h_cur  = 64'd1;
      k_prev = 64'd1;
      k_cur  = 64'd0;
      terms  = 0;
      forever begin
         if (h_cur > 64'(numer_lim) || k_cur > 64'(denom_lim)) begin
            h_cur = h_prev;
            k_cur = k_prev;
            break;
         end
         if (denom == 64'd0 || terms >= MAX_TERMS) break;
         quot  = numer / denom;
         rem   = numer % denom;
         numer = denom;
         denom = rem;
         grown  = mul_add_saturated(h_prev, quot, h_cur);
         h_prev = h_cur;
         h_cur  = grown;
         grown  = mul_add_saturated(k_prev, quot, k_cur);
         k_prev = k_cur;
         k_cur  = grown;
         terms++;
      end
      result.numer = h_cur[LIMIT_W-1:0];
      result.denom = k_cur[LIMIT_W-1:0];
      return result;
   endfunction

   // Operand with a random magnitude, zero and all ones now and then.
   function automatic logic [FIELD_W-1:0] random_operand();
      logic [FIELD_W-1:0] raw;
      raw = {$urandom, $urandom};
      case ($urandom_range(0, 7))
         0: raw = '0;
         1: raw = '1;
         2, 3: raw = raw >> $urandom_range(0, FIELD_W - 1);
         default: ;
      endcase
      return raw;
   endfunction

   // Build a fraction from random partial quotients so the expansion runs deep:
   // mostly small terms (long expansions), sometimes large ones.
   function automatic fraction_type built_fraction();
      logic [FIELD_W-1:0] numer, denom, partial, swap;
      logic [127:0] next;
      int depth;
      fraction_type value;
      numer = 64'd1;
      denom = 64'd0;
      depth = $urandom_range(1, 90);
      for (int i = 0; i < depth; i++) begin
         partial = ($urandom_range(0, 3) == 0) ? 64'($urandom_range(1, 100000))
                                               : 64'($urandom_range(1, 3));
         next = 128'(partial) * 128'(numer) + 128'(denom);
         if (next[127:64] != '0) break;
         denom = numer;
         numer = next[63:0];
      end
      if ($urandom_range(0, 1) == 1) begin
         swap  = numer;
         numer = denom;
         denom = swap;
      end
      value.numer = numer;
      value.denom = denom;
      return value;
   endfunction

   function automatic logic [LIMIT_W-1:0] random_limit();
      logic [LIMIT_W-1:0] lim;
      case ($urandom_range(0, 7))
         0: lim = '0;
         1: lim = LIMIT_W'(1);
         2: lim = '1;
         3: lim = LIMIT_RESET;
         4, 5: lim = LIMIT_W'($urandom_range(1, 1000));
         default: lim = LIMIT_W'($urandom);
      endcase
      return lim;
   endfunction

   task automatic queue_request(input logic [FIELD_W-1:0] numer,
                                input logic [FIELD_W-1:0] denom);
      fraction_type value;
      value.numer = numer;
      value.denom = denom;
      pending_fractions.push_back(value);
      requests_queued++;
   endtask

   task automatic queue_random_requests(input int count);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 9) < 6) begin
            pending_fractions.push_back(built_fraction());
            requests_queued++;
         end else begin
            queue_request(random_operand(), random_operand());
         end
      end
   endtask

   // Hold until every queued request has come back, then let the engine go quiet.
   task automatic wait_for_results();
      while (results_seen < requests_queued) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_limit(input csr_index_type index, input logic [LIMIT_W-1:0] data);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_write_data   <= data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      if (index == CSR_NUMERATOR_LIMIT) begin
         numerator_limit = data;
      end else begin
         denominator_limit = data;
      end
   endtask

   task automatic set_limits(input logic [LIMIT_W-1:0] numer_lim,
                             input logic [LIMIT_W-1:0] denom_lim);
      write_limit(CSR_NUMERATOR_LIMIT, numer_lim);
      write_limit(CSR_DENOMINATOR_LIMIT, denom_lim);
   endtask

   // Request driver: predict on acceptance, then present the next request or idle.
   // Valid gets at most one assignment per edge, so a back-to-back request never
   // sees valid dropped and raised in the same step.
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else if (!req_chan.valid || req_chan.ready) begin
         if (req_chan.valid) begin
            expected_convergents.push_back(best_convergent(
               {req_chan.value_numerator, req_chan.value_denominator},
               numerator_limit, denominator_limit));
         end
         if (pending_fractions.size() > 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
            fraction_type value;
            value = pending_fractions.pop_front();
            req_chan.valid             <= 1'b1;
            req_chan.value_numerator   <= value.numer;
            req_chan.value_denominator <= value.denom;
         end else begin
            req_chan.valid <= 1'b0;
         end
      end
   end

   // Result monitor: check each accepted result against the oldest prediction,
   // then decide whether to stall the next cycle.
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            results_seen++;
            if (expected_convergents.size() == 0) begin
               error_count++;
               $display("%0t: unexpected result %0d/%0d with no request outstanding",
                        $time, rsp_chan.approx_numerator, rsp_chan.approx_denominator);
            end else begin
               convergent_type want;
               want = expected_convergents.pop_front();
               if (rsp_chan.approx_numerator !== want.numer) begin
                  error_count++;
                  $display("%0t: approx_numerator expected %0d actual %0d",
                           $time, want.numer, rsp_chan.approx_numerator);
               end
               if (rsp_chan.approx_denominator !== want.denom) begin
                  error_count++;
                  $display("%0t: approx_denominator expected %0d actual %0d",
                           $time, want.denom, rsp_chan.approx_denominator);
               end
            end
         end
         rsp_chan.ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
      end
   end

   initial begin
      req_chan.valid             = 1'b0;
      req_chan.value_numerator   = '0;
      req_chan.value_denominator = '0;
      rsp_chan.ready             = 1'b0;
      csr_write_enable           = 1'b0;
      csr_index                  = CSR_NUMERATOR_LIMIT;
      csr_write_data             = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Directed requests against the reset limits, no idling.
      queue_request(64'd0, 64'd0);
      queue_request(64'd0, 64'd1);
      queue_request(64'd1, 64'd0);                 // zero denominator
      queue_request(64'd5, 64'd0);
      queue_request('1, '1);
      queue_request('1, 64'd1);                    // integer part far above the limit
      queue_request(64'd1, '1);                    // tiny value, falls back to 0/1
      queue_request(64'd1048575, 64'd1);           // exactly at the numerator limit
      queue_request(64'd1048576, 64'd1);           // one above it
      queue_request(64'd3, 64'd4);                 // exact, stops on zero remainder
      queue_request(64'd3141592653589793238, 64'd1000000000000000000);
      queue_request(64'd7540113804746346429, 64'd4660046610375530309);  // golden ratio
      queue_request(64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF);
      queue_request(64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555);
      queue_request(64'd123456789, 64'd987654321);
      wait_for_results();

      // Numerator limit zero: even the starting convergent is over it.
      set_limits('0, '1);
      queue_request(64'd7, 64'd3);
      queue_request(64'd0, 64'd0);
      queue_request('1, '1);
      wait_for_results();

      // Denominator limit zero.
      set_limits('1, '0);
      queue_request(64'd7, 64'd3);
      queue_request(64'd1, 64'd0);
      queue_request(64'd0, 64'd5);
      wait_for_results();

      // Random requests: widest limits with no idling, then random limits under
      // sender gaps, receiver stalls, and both together.
      set_limits('1, '1);
      queue_random_requests(RANDOM_PER_PHASE);
      wait_for_results();

      set_limits(random_limit(), random_limit());
      sender_idle_pct = 73;
      queue_random_requests(RANDOM_PER_PHASE);
      wait_for_results();

      set_limits(random_limit(), random_limit());
      sender_idle_pct    = 0;
      receiver_stall_pct = 73;
      queue_random_requests(RANDOM_PER_PHASE);
      wait_for_results();

      set_limits(LIMIT_W'($urandom), LIMIT_W'($urandom));
      sender_idle_pct    = 11;
      receiver_stall_pct = 11;
      queue_random_requests(RANDOM_PER_PHASE);

      // Drain, then give a stray result time to show up.
      while (results_seen < requests_queued) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0 && expected_convergents.size() == 0) begin
         $display("PASS bounded_rational_approximation");
      end else begin
         $display("FAIL bounded_rational_approximation");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest legal run of every request at the term cap.
   initial begin
      #20_000_000;
      $display("FAIL bounded_rational_approximation");
      $finish;
   end

endmodule
